/* sv/tts_pkg.sv */
package tts_pkg;

  typedef enum logic [2:0] {
    PH_HOVER   = 3'd0,
    PH_FRONT1  = 3'd1,
    PH_FRONT2  = 3'd2,
    PH_FORWARD = 3'd3,
    PH_BACK    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    REAR_ENABLED  = 2'd0,
    REAR_DISABLED = 2'd1,
    REAR_IDLE     = 2'd2
  } rear_e;

  typedef enum logic [2:0] {
    REG_FRONT_DUR = 3'd0,
    REG_BACK_DUR  = 3'd1,
    REG_TILT_HOV  = 3'd2,
    REG_TILT_MID  = 3'd3,
    REG_TILT_FWD  = 3'd4,
    REG_SW_AS     = 3'd5,
    REG_TRIM      = 3'd6
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEQ,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } state_e;

  localparam int unsigned CfgW        = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam logic [15:0] OneQ15      = 16'h8000;
  localparam logic [15:0] BlendAs     = 16'd2048;
  localparam logic [15:0] YawCutAs    = 16'd1280;
  localparam logic [31:0] FrontTwoUs  = 32'd500000;
  localparam logic [17:0] RampCap     = 18'd200000;
  localparam int unsigned MulW        = 17;
  localparam int unsigned DivW        = 49;

  typedef struct packed {
    logic [31:0] time_us;
    logic        fw_switch;
    logic [15:0] airspeed;
    logic signed [15:0] mc_roll;
    logic signed [15:0] mc_pitch;
    logic signed [15:0] mc_yaw;
    logic signed [15:0] mc_thrust;
    logic signed [15:0] fw_roll;
    logic signed [15:0] fw_pitch;
    logic signed [15:0] fw_yaw;
    logic signed [15:0] fw_throttle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] rotor_roll_out;
    logic signed [15:0] rotor_pitch_out;
    logic signed [15:0] rotor_yaw_out;
    logic signed [15:0] rotor_thrust_out;
    logic signed [15:0] elevon_roll_out;
    logic signed [15:0] elevon_pitch_out;
    logic signed [15:0] surface_yaw_out;
    logic signed [15:0] surface_throttle_out;
    logic signed [15:0] tilt_out;
    logic [2:0]  phase;
    logic [1:0]  rear_motor_mode;
    logic        idle_is_hover;
  } out_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

/* sv/tts_if.sv */
interface tts_in_if;
  logic         valid;
  logic         ready;
  tts_pkg::in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tts_out_if;
  logic          valid;
  logic          ready;
  tts_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/tts_serial_muldiv.sv */
// Bit-serial unsigned multiply then divide: q = a * b / d.
// One bit of the multiplier per cycle, then one quotient bit per cycle.
module tts_serial_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] d_i,
  output logic        done_o,
  output logic [48:0] q_o
);
  import tts_pkg::*;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_e;
  md_e md_q, md_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [48:0] prod_q, prod_d;
  logic [16:0] mplr_q, mplr_d;
  logic [31:0] mcnd_q, mcnd_d, div_q, div_d;
  logic [32:0] rem_q, rem_d, trial;
  logic        done_q, done_d;

  always_comb begin
    md_d = md_q; cnt_d = cnt_q; prod_d = prod_q; mplr_d = mplr_q;
    mcnd_d = mcnd_q; div_d = div_q; rem_d = rem_q; done_d = 1'b0;
    trial = '0;
    unique case (md_q)
      MD_IDLE: begin
        if (start_i) begin
          md_d = MD_MUL; cnt_d = 6'(MulW - 1); prod_d = '0;
          mplr_d = a_i; mcnd_d = b_i; div_d = d_i;
        end
      end
      MD_MUL: begin
        // MSB-first shift and add
        prod_d = {prod_q[47:0], 1'b0} + (mplr_q[16] ? {17'd0, mcnd_q} : 49'd0);
        mplr_d = {mplr_q[15:0], 1'b0};
        if (cnt_q == '0) begin
          md_d = MD_DIV; cnt_d = 6'(DivW - 1); rem_d = '0;
        end else cnt_d = cnt_q - 6'd1;
      end
      MD_DIV: begin
        trial = {rem_q[31:0], prod_q[48]};
        prod_d = {prod_q[47:0], 1'b0};
        if (trial >= {1'b0, div_q}) begin
          rem_d = trial - {1'b0, div_q}; prod_d[0] = 1'b1;
        end else rem_d = trial;
        if (cnt_q == '0) begin
          md_d = MD_IDLE; done_d = 1'b1;
        end else cnt_d = cnt_q - 6'd1;
      end
      default: md_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= MD_IDLE; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      md_q <= md_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d; mplr_q <= mplr_d; mcnd_q <= mcnd_d;
    div_q <= div_d; rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign q_o    = prod_q;
endmodule

/* sv/tiltrotor_transition_sequencer_core.sv */
// Tiltrotor transition sequencer: one result per control tick. A tilt ramp
// runs on a bit-serial unit (17 multiply plus 49 divide steps); in front part
// one the roll blend uses the same unit a second time. One tick is in flight
// at a time; the next is taken once the result has been handed off.
module tiltrotor_transition_sequencer_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [tts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tts_pkg::CfgW-1:0] cfg_data_i,
  tts_in_if.sink    in_if,
  tts_out_if.source out_if
);
  import tts_pkg::*;

  logic [12:0] fdur_q, bdur_q;
  logic signed [15:0] thov_q, tmid_q, tfwd_q, trim_q;
  logic [15:0] swas_q;

  phase_e ph_q, ph_d;
  logic [31:0] pst_q, pst_d;
  logic signed [15:0] tilt_q, tilt_d;
  logic [15:0] rw_q, rw_d, yw_q, yw_d;
  rear_e rear_q, rear_d;
  logic idle_q, idle_d;
  logic signed [15:0] hy_q, hy_d, ht_q, ht_d;

  state_e st_q, st_d;
  in_t it_q;
  out_t res_q, res_d;
  logic blend_q, blend_d;

  logic md_start, md_done;
  logic [16:0] md_a;
  logic [31:0] md_b, md_d;
  logic [48:0] md_q;
  logic ramp_on, need_blend;
  logic [12:0] fd_c, bd_c;

  tts_serial_muldiv u_md (
    .clk_i, .rst_ni, .start_i(md_start), .a_i(md_a), .b_i(md_b), .d_i(md_d),
    .done_o(md_done), .q_o(md_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdur_q <= 13'd1000; bdur_q <= 13'd1000; thov_q <= '0;
      tmid_q <= 16'sd9830; tfwd_q <= 16'sd32767; swas_q <= 16'd2560; trim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRONT_DUR: fdur_q <= cfg_data_i[12:0];
        REG_BACK_DUR:  bdur_q <= cfg_data_i[12:0];
        REG_TILT_HOV:  thov_q <= cfg_data_i;
        REG_TILT_MID:  tmid_q <= cfg_data_i;
        REG_TILT_FWD:  tfwd_q <= cfg_data_i;
        REG_SW_AS:     swas_q <= cfg_data_i;
        REG_TRIM:      trim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign fd_c = (fdur_q < 13'd1000) ? 13'd1000 : (fdur_q > 13'd5000) ? 13'd5000 : fdur_q;
  assign bd_c = (bdur_q > 13'd5000) ? 13'd5000 : bdur_q;

  // weight x by w/32768, truncated toward zero
  function automatic logic signed [15:0] weigh(input logic signed [15:0] x,
                                                 input logic [15:0] w);
    logic signed [33:0] p;
    logic signed [33:0] r;
    p = 34'(x) * $signed({18'd0, w});
    r = (p < 0) ? -((-p) >>> 15) : (p >>> 15);
    return sat16(r[19:0]);
  endfunction

  // ramp operands, chosen from phase after sequencing
  logic signed [16:0] rdiff;
  always_comb begin
    ramp_on = 1'b0; rdiff = '0; md_d = FrontTwoUs;
    unique case (ph_q)
      PH_FRONT1: begin
        ramp_on = tilt_q <= tmid_q; rdiff = 17'(tmid_q) - 17'(thov_q);
        md_d = 32'(fd_c) * 32'd1000;
      end
      PH_FRONT2: begin
        ramp_on = 1'b1; rdiff = 17'(tfwd_q) - 17'(tmid_q);
      end
      PH_BACK: begin
        ramp_on = (tilt_q > thov_q) && (bd_c != '0);
        rdiff = 17'(tfwd_q) - 17'(thov_q); md_d = 32'(bd_c) * 32'd1000;
      end
      default: ;
    endcase
    if (blend_q) begin
      md_d = 32'(swas_q - BlendAs);
    end
  end
  assign need_blend = (ph_q == PH_FRONT1) && (it_q.airspeed >= BlendAs)
                      && (swas_q > BlendAs);
  assign md_a = blend_q ? 17'(it_q.airspeed - BlendAs) : (rdiff[16] ? -rdiff : rdiff);
  assign md_b = blend_q ? 32'(OneQ15) : it_q.time_us - pst_q;

  always_comb begin
    st_d = st_q; md_start = 1'b0;
    unique case (st_q)
      ST_IDLE:  if (in_if.valid) st_d = ST_SEQ;
      ST_SEQ:   st_d = ST_MUL;
      ST_MUL: begin
        if (ramp_on || blend_q) begin md_start = 1'b1; st_d = ST_DIV; end
        else if (need_blend) st_d = ST_MUL;
        else st_d = ST_APPLY;
      end
      ST_DIV:   if (md_done) st_d = (need_blend && !blend_q) ? ST_MUL : ST_APPLY;
      ST_APPLY: st_d = ST_OUT;
      ST_OUT:   if (out_if.ready) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  assign in_if.ready  = (st_q == ST_IDLE);
  assign out_if.valid = (st_q == ST_OUT);
  assign out_if.payload = res_q;

  logic signed [19:0] qsat;
  logic signed [15:0] nroll;
  always_comb begin
    ph_d = ph_q; pst_d = pst_q; tilt_d = tilt_q; rw_d = rw_q; yw_d = yw_q;
    rear_d = rear_q; idle_d = idle_q; hy_d = hy_q; ht_d = ht_q;
    res_d = res_q; blend_d = blend_q;
    qsat = (md_q > 49'(RampCap)) ? 20'(RampCap) : 20'(md_q[17:0]);
    nroll = sat16(-20'(it_q.fw_roll));
    unique case (st_q)
      ST_SEQ: begin
        blend_d = 1'b0;
        if (!it_q.fw_switch) begin
          unique case (ph_q)
            PH_HOVER:   tilt_d = thov_q;
            PH_FORWARD: begin ph_d = PH_BACK; pst_d = it_q.time_us; end
            PH_FRONT1, PH_FRONT2: ph_d = PH_HOVER;
            default: if (tilt_q <= thov_q) begin ph_d = PH_HOVER; tilt_d = thov_q; end
          endcase
        end else begin
          unique case (ph_q)
            PH_HOVER:   begin ph_d = PH_FRONT1; pst_d = it_q.time_us; end
            PH_FORWARD: tilt_d = tfwd_q;
            PH_FRONT1:  if (it_q.airspeed >= swas_q) begin
                          ph_d = PH_FRONT2; pst_d = it_q.time_us;
                        end
            PH_FRONT2:  if (tilt_q >= tfwd_q) begin ph_d = PH_FORWARD; tilt_d = tfwd_q; end
            default: ;
          endcase
        end
      end
      ST_MUL: if (!ramp_on && !blend_q && need_blend) blend_d = 1'b1;
      ST_DIV: if (md_done) begin
        if (blend_q) begin
          rw_d = (md_q >= 49'(OneQ15)) ? 16'd0 : OneQ15 - md_q[15:0];
        end else begin
          unique case (ph_q)
            PH_FRONT1: tilt_d = sat16(20'(thov_q) + qsat);
            PH_FRONT2: tilt_d = sat16(20'(tmid_q) + qsat);
            default:   tilt_d = sat16(20'(tfwd_q) - qsat);
          endcase
          if (need_blend) blend_d = 1'b1;
        end
      end
      ST_APPLY: begin
        unique case (ph_q)
          PH_HOVER:   begin rear_d = REAR_ENABLED; idle_d = 1'b1; end
          PH_FORWARD: begin rear_d = REAR_DISABLED; idle_d = 1'b0; end
          PH_FRONT1: begin
            rear_d = REAR_ENABLED;
            if (it_q.airspeed < BlendAs) rw_d = OneQ15;
            else if (swas_q <= BlendAs) rw_d = '0;
            yw_d = (it_q.airspeed > YawCutAs) ? 16'd0 : OneQ15;
          end
          PH_FRONT2: rw_d = '0;
          default: begin
            rear_d = REAR_IDLE; rw_d = '0;
            if (tilt_q > thov_q && bd_c == '0) tilt_d = thov_q;
          end
        endcase
      end
      ST_OUT: ;
      default: ;
    endcase

    // result formed from updated state during apply and registered for output
    if (st_q == ST_APPLY) begin
      res_d.rotor_roll_out = '0; res_d.rotor_pitch_out = '0;
      res_d.rotor_yaw_out = '0;
      res_d.rotor_thrust_out = it_q.fw_throttle;
      res_d.elevon_roll_out = nroll;
      res_d.elevon_pitch_out = sat16(20'(it_q.fw_pitch) + 20'(trim_q));
      res_d.surface_yaw_out = hy_q; res_d.surface_throttle_out = ht_q;
      unique case (ph_q)
        PH_HOVER: begin
          res_d.rotor_roll_out = it_q.mc_roll; res_d.rotor_pitch_out = it_q.mc_pitch;
          res_d.rotor_yaw_out = it_q.mc_yaw; res_d.rotor_thrust_out = it_q.mc_thrust;
          res_d.elevon_roll_out = '0; res_d.elevon_pitch_out = '0;
        end
        PH_FRONT1: begin
          res_d.rotor_roll_out = weigh(it_q.mc_roll, rw_d);
          res_d.rotor_pitch_out = it_q.mc_pitch;
          res_d.rotor_yaw_out = weigh(it_q.mc_yaw, yw_d);
          res_d.rotor_thrust_out = it_q.mc_thrust;
          res_d.elevon_roll_out = weigh(nroll, OneQ15 - rw_d);
        end
        PH_BACK: begin
          res_d.rotor_roll_out = weigh(it_q.mc_roll, rw_d);
          res_d.rotor_pitch_out = it_q.mc_pitch;
          res_d.rotor_yaw_out = weigh(it_q.mc_yaw, yw_q);
        end
        default: ;
      endcase
      if (ph_q != PH_HOVER && ph_q != PH_FRONT1) begin
        hy_d = it_q.fw_yaw; ht_d = it_q.fw_throttle;
        res_d.surface_yaw_out = it_q.fw_yaw;
        res_d.surface_throttle_out = it_q.fw_throttle;
      end
      res_d.tilt_out = tilt_d;
      res_d.phase = ph_q;
      res_d.rear_motor_mode = rear_d;
      res_d.idle_is_hover = idle_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ph_q <= PH_HOVER; pst_q <= '0; tilt_q <= '0;
      rw_q <= OneQ15; yw_q <= OneQ15; rear_q <= REAR_ENABLED; idle_q <= 1'b0;
      hy_q <= '0; ht_q <= '0; blend_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; pst_q <= pst_d; tilt_q <= tilt_d;
      rw_q <= rw_d; yw_q <= yw_d; rear_q <= rear_d; idle_q <= idle_d;
      hy_q <= hy_d; ht_q <= ht_d; blend_q <= blend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) it_q <= in_if.payload;
    res_q <= res_d;
  end
endmodule
